[sv/signed_restoring_divider_macros.svh]
// Assertion macros for the signed restoring divider.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef SIGNED_RESTORING_DIVIDER_MACROS_SVH
`define SIGNED_RESTORING_DIVIDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRDIV_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srdiv assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SRDIV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srdiv assertion failed");

`endif

[sv/srdiv_pkg.sv]
`default_nettype none

package srdiv_pkg;

    // Operand and result width.
    localparam int DATA_WIDTH = 32;

    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] ALL_ONES = {DATA_WIDTH{1'b1}};

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] dividend;
        logic signed [DATA_WIDTH-1:0] divisor;
    } req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] quotient;
        logic                         divide_by_zero;
        logic                         overflow;
    } rsp_t;

    // Data carried down the chain of cells. The num_quo field starts as the
    // dividend magnitude and is shifted left one place per cell, with each
    // new quotient bit entering at the bottom.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] num_quo;
        logic [DATA_WIDTH-1:0] den;
        logic                  neg_quo;
        logic                  neg_dividend;
        logic                  div_zero;
        logic                  ovf;
    } cell_data_t;

endpackage

`default_nettype wire

[sv/srdiv_cell.sv]
`default_nettype none

module srdiv_cell
    import srdiv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic       valid_in,
    input  wire cell_data_t data_in,
    output logic            valid_out,
    output cell_data_t      data_out
);

    logic                  valid_reg;
    logic                  valid_next;
    cell_data_t            data_reg;
    cell_data_t            data_next;
    logic [DATA_WIDTH:0]   rem_shift;
    logic [DATA_WIDTH:0]   diff;
    logic                  take;

    // One restoring step: bring down the next dividend bit, subtract the
    // divisor if it fits, otherwise keep the shifted remainder.
    always_comb
    begin
        rem_shift = {data_in.rem, data_in.num_quo[DATA_WIDTH-1]};
        diff      = rem_shift - {1'b0, data_in.den};
        take      = (rem_shift >= {1'b0, data_in.den});

        data_next         = data_in;
        data_next.rem     = take ? diff[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
        data_next.num_quo = {data_in.num_quo[DATA_WIDTH-2:0], take};

        valid_next = advance ? valid_in : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

[sv/srdiv_post.sv]
`default_nettype none

module srdiv_post
    import srdiv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic       valid_in,
    input  wire cell_data_t data_in,
    output logic            valid_out,
    output rsp_t            rsp_out
);

    logic                  valid_reg;
    logic                  valid_next;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;
    logic [DATA_WIDTH-1:0] quo_mag;
    logic [DATA_WIDTH-1:0] quo_neg;

    // Apply the sign to the magnitude quotient and override it in the
    // zero-divisor and overflow cases.
    always_comb
    begin
        quo_mag = data_in.num_quo;
        quo_neg = DATA_WIDTH'(~quo_mag + 1'b1);

        rsp_next.divide_by_zero = data_in.div_zero;
        rsp_next.overflow       = data_in.ovf && !data_in.div_zero;

        if (data_in.div_zero)
        begin
            rsp_next.quotient = data_in.neg_dividend ? (MIN_NEG + 1'b1) : MAX_POS;
        end
        else if (data_in.ovf)
        begin
            rsp_next.quotient = MAX_POS;
        end
        else
        begin
            rsp_next.quotient = data_in.neg_quo ? quo_neg : quo_mag;
        end

        valid_next = advance ? valid_in : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign valid_out = valid_reg;
    assign rsp_out   = rsp_reg;

endmodule

`default_nettype wire

[sv/signed_restoring_divider.sv]
// Signed restoring divider, pipelined as a chain of one-bit cells.
//
// Request channel (req_valid, req_stall, req): each beat carries a signed
// dividend and divisor. Response channel (rsp_valid, rsp_stall, rsp): each
// beat carries the quotient truncated toward zero and two flags. Every
// request beat produces exactly one response beat, in order.
// A beat moves at a rising edge where valid is high and stall is low.
//
// The chain holds one cell per quotient bit, each doing one compare and
// subtract, then one output register that applies the sign and the special
// cases. Throughput is one beat per cycle while the receiver keeps
// rsp_stall low.
//
// A zero divisor gives the largest positive value, or its negation when
// the dividend is negative, with divide_by_zero set. The most negative
// value over minus one gives the largest positive value with overflow set.
//
// The whole chain advances together. When the output register holds a beat
// that the receiver stalls, the chain freezes and req_stall is raised in
// the same cycle. Reset clears every valid bit, so the block starts empty.

`default_nettype none

`include "signed_restoring_divider_macros.svh"

module signed_restoring_divider
    import srdiv_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    logic                  advance;
    logic [DATA_WIDTH-1:0] dividend_u;
    logic [DATA_WIDTH-1:0] divisor_u;
    logic                  neg_a;
    logic                  neg_b;
    cell_data_t            front;

    // Stage boundaries: index 0 is the chain input, index DATA_WIDTH its end.
    logic                  chain_valid [DATA_WIDTH+1];
    cell_data_t            chain_data  [DATA_WIDTH+1];

    // The chain moves whenever the output register is empty or being drained.
    assign advance   = !rsp_valid || !rsp_stall;
    assign req_stall = !advance;

    // Form the magnitudes and note the special cases before the first cell.
    always_comb
    begin
        dividend_u = req.dividend;
        divisor_u  = req.divisor;
        neg_a      = dividend_u[DATA_WIDTH-1];
        neg_b      = divisor_u[DATA_WIDTH-1];

        front.rem          = '0;
        front.num_quo      = neg_a ? DATA_WIDTH'(~dividend_u + 1'b1) : dividend_u;
        front.den          = neg_b ? DATA_WIDTH'(~divisor_u + 1'b1) : divisor_u;
        front.neg_quo      = neg_a ^ neg_b;
        front.neg_dividend = neg_a;
        front.div_zero     = (divisor_u == '0);
        front.ovf          = (dividend_u == MIN_NEG) && (divisor_u == ALL_ONES);
    end

    assign chain_valid[0] = req_valid;
    assign chain_data[0]  = front;

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        srdiv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (chain_valid[i]),
            .data_in   (chain_data[i]),
            .valid_out (chain_valid[i+1]),
            .data_out  (chain_data[i+1])
        );
    end

    srdiv_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (chain_valid[DATA_WIDTH]),
        .data_in   (chain_data[DATA_WIDTH]),
        .valid_out (rsp_valid),
        .rsp_out   (rsp)
    );

    // The two flags never come together.
    `SRDIV_ASSERT_SAME(a_flags_exclusive, rsp_valid, !(rsp.divide_by_zero && rsp.overflow))
    // An overflow result is always saturated to the largest positive value.
    `SRDIV_ASSERT_SAME(a_ovf_saturates, rsp_valid && rsp.overflow, rsp.quotient == MAX_POS)
    // A zero divisor gives the largest positive value or its negation.
    `SRDIV_ASSERT_SAME(a_dz_value, rsp_valid && rsp.divide_by_zero,
        (rsp.quotient == MAX_POS) || (rsp.quotient == (MIN_NEG + 1'b1)))
    // A stalled response freezes the last cell, so its beat is still there.
    `SRDIV_ASSERT_NEXT(a_chain_frozen, rsp_valid && rsp_stall && chain_valid[DATA_WIDTH],
        chain_valid[DATA_WIDTH])

endmodule

`default_nettype wire

[test/signed_restoring_divider_tb.sv]
`default_nettype none

module signed_restoring_divider_tb;

    import srdiv_pkg::*;

    // Cycles allowed after the last response for anything still in the chain.
    localparam int SETTLE_CYCLES = DATA_WIDTH + 8;
    // Only the first few mismatches are printed in full; the rest are counted.
    localparam int REPORT_LIMIT = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Responses still owed by the divider, oldest at the front.
    rsp_t pending_quotients[$];
    int unsigned mismatch_count = 0;

    // Traffic shaping, changed by the test tasks between phases.
    bit sender_gaps_on = 1'b0;
    bit receiver_stalls_on = 1'b0;
    // A non-zero value asks the receiver process for one long hold-off.
    int unsigned hold_off_request = 0;

    signed_restoring_divider dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the response for one request beat. The magnitudes are divided
    // by restoring shift-and-subtract, then the sign is applied; a zero
    // divisor and the most negative value over minus one are saturated.
    function automatic rsp_t expected_quotient(input req_t operands);
        rsp_t result;
        logic [DATA_WIDTH-1:0] num_mag;
        logic [DATA_WIDTH-1:0] den_mag;
        logic [DATA_WIDTH-1:0] partial;
        logic [DATA_WIDTH-1:0] quo_mag;
        logic carry;
        logic dividend_neg;
        logic divisor_neg;
        dividend_neg = operands.dividend[DATA_WIDTH-1];
        divisor_neg = operands.divisor[DATA_WIDTH-1];
        result = '0;
        if (operands.divisor == '0)
        begin
            result.divide_by_zero = 1'b1;
            result.quotient = dividend_neg ? -MAX_POS : MAX_POS;
        end
        else if (operands.dividend == MIN_NEG && operands.divisor == ALL_ONES)
        begin
            result.overflow = 1'b1;
            result.quotient = MAX_POS;
        end
        else
        begin
            // Negating the most negative value gives back the same bits,
            // which read as an unsigned magnitude is exactly right.
            num_mag = dividend_neg ? -operands.dividend : operands.dividend;
            den_mag = divisor_neg ? -operands.divisor : operands.divisor;
            partial = '0;
            quo_mag = '0;
            for (int i = DATA_WIDTH - 1; i >= 0; i--)
            begin
                // The bit shifted out of the top of the partial remainder
                // means it already exceeds any divisor magnitude.
                carry = partial[DATA_WIDTH-1];
                partial = {partial[DATA_WIDTH-2:0], num_mag[i]};
                if (carry || partial >= den_mag)
                begin
                    partial = partial - den_mag;
                    quo_mag[i] = 1'b1;
                end
            end
            result.quotient = (dividend_neg != divisor_neg) ? -quo_mag : quo_mag;
        end
        return result;
    endfunction

    // Pause lengths for both sides: mostly short, now and then a long one so
    // that gaps land on every stage of the chain.
    function automatic int unsigned random_pause_length();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Operands weighted towards the interesting corners: the saturating and
    // sign-boundary values, small numbers (zero divisors among them), values
    // of every magnitude and plain full-width random patterns.
    function automatic logic signed [DATA_WIDTH-1:0] random_operand();
        logic signed [DATA_WIDTH-1:0] value;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 6))
                    0: value = '0;
                    1: value = 1;
                    2: value = -1;
                    3: value = MAX_POS;
                    4: value = MIN_NEG;
                    5: value = MIN_NEG + 1;
                    default: value = MAX_POS - 1;
                endcase
            end
            1, 2: value = $signed($urandom_range(0, 32)) - 16;
            3:
            begin
                value = $urandom >> $urandom_range(0, DATA_WIDTH - 1);
                if ($urandom_range(0, 1))
                    value = -value;
            end
            default: value = $urandom;
        endcase
        return value;
    endfunction

    // Presents one beat and waits for the divider to take it. The caller is
    // always at a rising edge, so the new payload is driven for the next one.
    // Valid is left high so that back-to-back beats never drop it.
    task automatic send_operands(input logic signed [DATA_WIDTH-1:0] dividend,
                                 input logic signed [DATA_WIDTH-1:0] divisor);
        req_t operands;
        operands.dividend = dividend;
        operands.divisor = divisor;
        req <= operands;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        pending_quotients.push_back(expected_quotient(operands));
    endtask

    // Between beats the sender sometimes drops valid for a while.
    task automatic sender_pause();
        if (sender_gaps_on && $urandom_range(0, 99) < 30)
        begin
            req_valid <= 1'b0;
            repeat (random_pause_length()) @(posedge clk);
        end
    endtask

    task automatic send_random_beats(input int unsigned count);
        for (int unsigned n = 0; n < count; n++)
        begin
            send_operands(random_operand(), random_operand());
            sender_pause();
        end
    endtask

    // The sender stops offering until every outstanding response is back.
    task automatic wait_until_drained();
        req_valid <= 1'b0;
        while (pending_quotients.size() != 0)
            @(posedge clk);
    endtask

    // Extremes of both operands, every sign combination and every special
    // case: zero divisor with each sign of dividend, most negative over
    // minus one, and the most negative dividend over other divisors.
    task automatic test_directed_cases();
        sender_gaps_on = 1'b0;
        receiver_stalls_on = 1'b0;
        send_operands(0, 1);
        send_operands(0, -1);
        send_operands(MAX_POS, 1);
        send_operands(MAX_POS, -1);
        send_operands(MIN_NEG, 1);
        send_operands(MIN_NEG, -1);
        send_operands(MIN_NEG, MIN_NEG);
        send_operands(MIN_NEG, MAX_POS);
        send_operands(MIN_NEG, 2);
        send_operands(MIN_NEG, -2);
        send_operands(MAX_POS, MIN_NEG);
        send_operands(-1, MIN_NEG);
        send_operands(MAX_POS, MAX_POS);
        send_operands(1, MAX_POS);
        send_operands(7, 2);
        send_operands(-7, 2);
        send_operands(7, -2);
        send_operands(-7, -2);
        send_operands(0, 0);
        send_operands(5, 0);
        send_operands(-5, 0);
        send_operands(MAX_POS, 0);
        send_operands(MIN_NEG, 0);
        send_operands(-1, 1);
        wait_until_drained();
    endtask

    // A stretch at full rate with no idling on either side.
    task automatic test_back_to_back();
        sender_gaps_on = 1'b0;
        receiver_stalls_on = 1'b0;
        send_random_beats(150);
        wait_until_drained();
    endtask

    // The bulk of the run: random operands with both sides idling at random.
    task automatic test_random_traffic();
        sender_gaps_on = 1'b1;
        receiver_stalls_on = 1'b1;
        send_random_beats(600);
        wait_until_drained();
    endtask

    // The receiver holds off for far longer than the chain is deep while the
    // sender keeps offering, so the divider fills and stalls its input.
    task automatic test_receiver_hold_off();
        sender_gaps_on = 1'b0;
        receiver_stalls_on = 1'b0;
        hold_off_request = 3 * DATA_WIDTH;
        send_random_beats(100);
        wait_until_drained();
    endtask

    // The sender stops mid-stream until every response has come back, then
    // carries on with random idling on both sides.
    task automatic test_sender_pause();
        sender_gaps_on = 1'b1;
        receiver_stalls_on = 1'b1;
        send_random_beats(50);
        wait_until_drained();
        send_random_beats(80);
        wait_until_drained();
    endtask

    // Receiver: random stalls of random length, plus the one long hold-off
    // asked for by the tasks, counted out here cycle by cycle.
    always @(posedge clk)
    begin : receiver
        int unsigned stall_left;
        if (hold_off_request != 0)
        begin
            stall_left = hold_off_request;
            hold_off_request = 0;
        end
        if (stall_left != 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else if (receiver_stalls_on && $urandom_range(0, 99) < 15)
        begin
            rsp_stall <= 1'b1;
            stall_left = random_pause_length() - 1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // Every response beat is matched against the oldest expectation.
    // Values are sampled at the edge, before anything driven there settles.
    always @(posedge clk)
    begin : response_check
        rsp_t expected;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_quotients.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Unexpected response beat: quotient %0d dz %b ov %b",
                             rsp.quotient, rsp.divide_by_zero, rsp.overflow);
            end
            else
            begin
                expected = pending_quotients.pop_front();
                if (rsp.quotient !== expected.quotient
                    || rsp.divide_by_zero !== expected.divide_by_zero
                    || rsp.overflow !== expected.overflow)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"Mismatch: expected quotient %0d dz %b ov %b, ",
                                  "got %0d dz %b ov %b"},
                                 expected.quotient, expected.divide_by_zero,
                                 expected.overflow, rsp.quotient,
                                 rsp.divide_by_zero, rsp.overflow);
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_back_to_back();
        test_random_traffic();
        test_receiver_hold_off();
        test_sender_pause();

        // Nothing is owed any more; let the chain run on in case a stray
        // beat is still on its way out.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Guard against a hung handshake: well beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
